### rtl/core/ptrq_pkg.sv
// shared item types and operation codes for the persistent trie range query block
package ptrq_pkg;

    typedef struct packed {
        logic [2:0]  mode;
        logic [10:0] left_pos;
        logic [10:0] right_pos;
        logic [20:0] value_arg;
    } req_t;

    typedef struct packed {
        logic        status;
        logic [20:0] answer;
    } rsp_t;

    localparam logic [2:0] MODE_PUSH  = 3'd0;
    localparam logic [2:0] MODE_XOR   = 3'd1;
    localparam logic [2:0] MODE_POP   = 3'd2;
    localparam logic [2:0] MODE_COUNT = 3'd3;
    localparam logic [2:0] MODE_KTH   = 3'd4;

    localparam logic ST_OK  = 1'b0;
    localparam logic ST_ERR = 1'b1;

endpackage

### rtl/core/ptrq_step_unit.sv
// shared count-difference, compare and subtract unit for one trie level
module ptrq_step_unit #(
    parameter int CW = 11
) (
    input  logic [2:0]    op,
    input  logic          bit_in,
    input  logic [CW-1:0] cnt_a,
    input  logic [CW-1:0] cnt_b,
    input  logic [CW-1:0] k_in,
    input  logic [CW-1:0] sum_in,
    output logic          take,
    output logic [CW-1:0] k_out,
    output logic [CW-1:0] sum_out,
    output logic [CW-1:0] sum_leaf
);
    import ptrq_pkg::*;

    logic [CW-1:0] diff;

    assign diff     = cnt_b - cnt_a;
    assign sum_leaf = sum_in + diff;

    always_comb
    begin
        take    = 1'b0;
        k_out   = k_in;
        sum_out = sum_in;
        case (op)
            MODE_XOR:
            begin
                take = (diff != '0);
            end
            MODE_COUNT:
            begin
                // a one bit counts the whole zero subtree below
                take = !bit_in;
                if (bit_in)
                begin
                    sum_out = sum_leaf;
                end
            end
            MODE_KTH:
            begin
                take = (diff >= k_in);
                if (!take)
                begin
                    k_out = k_in - diff;
                end
            end
            default:
            begin
                take = 1'b0;
            end
        endcase
    end

endmodule

### rtl/core/persistent_trie_range_query.sv
// top level of the persistent trie range query block: sequencer, node and root memories
//
// usage
//   req channel (req_valid / req_stall / req_item) takes one item at a time;
//   req_stall is high while an item is being worked on
//   rsp channel (rsp_valid / rsp_stall / rsp_item) gives exactly one result
//   per item: status and answer; the result sits in an output register
// sequence per item
//   every mode ends in S_FIN, which loads the output register; the next item
//   is taken only after that; pop, errors and unknown modes: S_DEC, S_FIN
//   push: S_DEC, P_ROOT (root read and new root write), P_LOAD, then P_WR
//   writes one node per cycle, set by the chain of dependent reads
//   through the previous version
//   queries: S_DEC, Q_ROOT, Q_LOAD, then per trie level Q_GET reads the
//   current node pair and Q_PROBE the probed child pair through the shared
//   step unit; a level needs both states because of the memory read
//   latency
// reset
//   stack empty, allocation pointer at node one; node zero and root zero
//   read as the empty trie without any clearing pass
// stall
//   when rsp_stall holds a result, a finished item waits in its last
//   state and no new item is taken
module persistent_trie_range_query #(
    parameter int MAX_ITEMS  = 1024,
    parameter int VALUE_BITS = 21
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  ptrq_pkg::req_t req_item,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output ptrq_pkg::rsp_t rsp_item
);
    import ptrq_pkg::*;

    localparam int NodesPerPush = VALUE_BITS + 1;
    localparam int NodeCount    = 1 + MAX_ITEMS * NodesPerPush;
    localparam int NW           = $clog2(NodeCount);
    localparam int DW           = $clog2(MAX_ITEMS + 1);
    localparam int CW           = DW;
    localparam int LW           = $clog2(VALUE_BITS + 1);

    typedef struct packed {
        logic [CW-1:0]         cnt;
        logic [NW-1:0]         ch1;
        logic [NW-1:0]         ch0;
        logic [VALUE_BITS-1:0] val;
    } node_t;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_DEC   = 10'b0000000010,
        S_FIN   = 10'b0000000100,
        Q_ROOT  = 10'b0000001000,
        Q_LOAD  = 10'b0000010000,
        Q_GET   = 10'b0000100000,
        Q_PROBE = 10'b0001000000,
        P_ROOT  = 10'b0010000000,
        P_LOAD  = 10'b0100000000,
        P_WR    = 10'b1000000000
    } state_t;

    function automatic logic [NW-1:0] child_of(input node_t n, input logic sel);
        return sel ? n.ch1 : n.ch0;
    endfunction

    // control and working registers
    state_t        state_reg, state_next;
    req_t          item_reg, item_next;
    logic [DW-1:0] depth_reg, depth_next;
    logic [NW-1:0] nf_reg, nf_next;
    logic [LW-1:0] lvl_reg, lvl_next;
    node_t         a_reg, a_next;
    node_t         b_reg, b_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] sum_reg, sum_next;
    logic          status_reg, status_next;
    logic [20:0]   answer_reg, answer_next;
    logic          rsp_valid_reg, rsp_valid_next;
    rsp_t          rsp_reg, rsp_next;

    // memories
    node_t         node_mem [NodeCount];
    logic [NW-1:0] root_mem [MAX_ITEMS+1];

    logic          node_we;
    logic [NW-1:0] node_waddr;
    node_t         node_wdata;
    logic [NW-1:0] node_ra, node_rb;
    node_t         nrd_a_reg, nrd_b_reg;
    logic          nz_a_reg, nz_b_reg;
    node_t         node_a, node_b;

    logic          root_we;
    logic [DW-1:0] root_waddr;
    logic [NW-1:0] root_wdata;
    logic [DW-1:0] root_ra, root_rb;
    logic [NW-1:0] rrd_a_reg, rrd_b_reg;
    logic          rz_a_reg, rz_b_reg;
    logic [NW-1:0] root_a, root_b;

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_waddr] <= node_wdata;
        end
        nrd_a_reg <= node_mem[node_ra];
        nrd_b_reg <= node_mem[node_rb];
    end

    always_ff @(posedge clk)
    begin
        if (root_we)
        begin
            root_mem[root_waddr] <= root_wdata;
        end
        rrd_a_reg <= root_mem[root_ra];
        rrd_b_reg <= root_mem[root_rb];
    end

    // node zero and root zero are never written and read as the empty trie
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nz_a_reg <= 1'b1;
            nz_b_reg <= 1'b1;
            rz_a_reg <= 1'b1;
            rz_b_reg <= 1'b1;
        end
        else
        begin
            nz_a_reg <= (node_ra == '0);
            nz_b_reg <= (node_rb == '0);
            rz_a_reg <= (root_ra == '0);
            rz_b_reg <= (root_rb == '0);
        end
    end

    assign node_a = nz_a_reg ? '0 : nrd_a_reg;
    assign node_b = nz_b_reg ? '0 : nrd_b_reg;
    assign root_a = rz_a_reg ? '0 : rrd_a_reg;
    assign root_b = rz_b_reg ? '0 : rrd_b_reg;

    // decode helpers
    logic [31:0]           lp32, rp32, arg32, depth32, len32, nf32;
    logic [VALUE_BITS-1:0] vval;
    logic [LW-1:0]         lvl_m1;
    logic [VALUE_BITS-1:0] vshift;
    logic                  cur_bit;
    logic                  pbit;
    logic [DW-1:0]         depth_after;
    logic [31:0]           ans32;
    logic [31:0]           sum32;

    assign lp32    = 32'(item_reg.left_pos);
    assign rp32    = 32'(item_reg.right_pos);
    assign arg32   = 32'(item_reg.value_arg);
    assign depth32 = 32'(depth_reg);
    assign len32   = rp32 - lp32 + 32'd1;
    assign vval    = arg32[VALUE_BITS-1:0];
    assign lvl_m1  = lvl_reg - LW'(1);
    assign vshift  = vval >> lvl_m1;
    assign cur_bit = vshift[0];
    // max xor probes the opposite bit, the other queries probe the zero side
    assign pbit    = (item_reg.mode == MODE_XOR) ? !cur_bit : 1'b0;

    assign depth_after = depth_reg - arg32[DW-1:0];
    assign nf32        = 32'd1 + 32'(depth_after) * 32'(NodesPerPush);

    // shared step unit, always fed from the node read ports
    logic          take;
    logic [CW-1:0] k_out, sum_out, sum_leaf;

    ptrq_step_unit #(
        .CW (CW)
    ) u_step (
        .op       (item_reg.mode),
        .bit_in   (cur_bit),
        .cnt_a    (node_a.cnt),
        .cnt_b    (node_b.cnt),
        .k_in     (k_reg),
        .sum_in   (sum_reg),
        .take     (take),
        .k_out    (k_out),
        .sum_out  (sum_out),
        .sum_leaf (sum_leaf)
    );

    assign ans32 = 32'(node_b.val);
    assign sum32 = 32'(sum_leaf);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        depth_next     = depth_reg;
        nf_next        = nf_reg;
        lvl_next       = lvl_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        k_next         = k_reg;
        sum_next       = sum_reg;
        status_next    = status_reg;
        answer_next    = answer_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;

        node_we    = 1'b0;
        node_waddr = nf_reg;
        node_wdata = node_a;
        node_ra    = '0;
        node_rb    = '0;
        root_we    = 1'b0;
        root_waddr = DW'(depth32 + 32'd1);
        root_wdata = nf_reg;
        root_ra    = '0;
        root_rb    = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    item_next  = req_item;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                status_next = ST_ERR;
                answer_next = '0;
                lvl_next    = LW'(VALUE_BITS);
                sum_next    = '0;
                k_next      = arg32[CW-1:0];
                state_next  = S_FIN;
                case (item_reg.mode)
                    MODE_PUSH:
                    begin
                        if (depth32 < 32'(MAX_ITEMS))
                        begin
                            state_next = P_ROOT;
                        end
                    end
                    MODE_POP:
                    begin
                        if (arg32 <= depth32)
                        begin
                            status_next = ST_OK;
                            depth_next  = depth_after;
                            nf_next     = nf32[NW-1:0];
                        end
                    end
                    MODE_XOR, MODE_COUNT, MODE_KTH:
                    begin
                        if (lp32 != 32'd0 && lp32 <= rp32 && rp32 <= depth32)
                        begin
                            if (item_reg.mode != MODE_KTH ||
                                (arg32 != 32'd0 && arg32 <= len32))
                            begin
                                state_next = Q_ROOT;
                            end
                        end
                    end
                    default:
                    begin
                        status_next = ST_ERR;
                    end
                endcase
            end
            Q_ROOT:
            begin
                root_ra    = DW'(lp32 - 32'd1);
                root_rb    = DW'(rp32);
                state_next = Q_LOAD;
            end
            Q_LOAD:
            begin
                node_ra    = root_a;
                node_rb    = root_b;
                state_next = Q_GET;
            end
            Q_GET:
            begin
                // read ports hold the current node pair
                a_next = node_a;
                b_next = node_b;
                if (lvl_reg == '0)
                begin
                    status_next = ST_OK;
                    answer_next = (item_reg.mode == MODE_COUNT) ? sum32[20:0] : ans32[20:0];
                    state_next  = S_FIN;
                end
                else
                begin
                    node_ra    = child_of(node_a, pbit);
                    node_rb    = child_of(node_b, pbit);
                    state_next = Q_PROBE;
                end
            end
            Q_PROBE:
            begin
                // read ports hold the probed children; fetch the chosen pair
                k_next   = k_out;
                sum_next = sum_out;
                lvl_next = lvl_m1;
                node_ra  = child_of(a_reg, take ? pbit : !pbit);
                node_rb  = child_of(b_reg, take ? pbit : !pbit);
                state_next = Q_GET;
            end
            P_ROOT:
            begin
                root_ra    = depth_reg;
                root_we    = 1'b1;
                state_next = P_LOAD;
            end
            P_LOAD:
            begin
                node_ra    = root_a;
                state_next = P_WR;
            end
            P_WR:
            begin
                // copy of the old node with one more occurrence
                node_we        = 1'b1;
                node_wdata     = node_a;
                node_wdata.cnt = node_a.cnt + CW'(1);
                nf_next        = nf_reg + NW'(1);
                if (lvl_reg == '0)
                begin
                    node_wdata.val = vval;
                    depth_next     = depth_reg + DW'(1);
                    status_next    = ST_OK;
                    answer_next    = '0;
                    state_next     = S_FIN;
                end
                else
                begin
                    if (cur_bit)
                    begin
                        node_wdata.ch1 = nf_reg + NW'(1);
                    end
                    else
                    begin
                        node_wdata.ch0 = nf_reg + NW'(1);
                    end
                    node_ra  = child_of(node_a, cur_bit);
                    lvl_next = lvl_m1;
                end
            end
            S_FIN:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_next.status = status_reg;
                    rsp_next.answer = answer_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            depth_reg     <= '0;
            nf_reg        <= NW'(1);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            nf_reg        <= nf_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        lvl_reg    <= lvl_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        k_reg      <= k_next;
        sum_reg    <= sum_next;
        status_reg <= status_next;
        answer_reg <= answer_next;
        rsp_reg    <= rsp_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_reg;

    // allocation pointer always follows the stack depth between items
    a_nf_track: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |->
        (32'(nf_reg) == 32'd1 + 32'(depth_reg) * 32'(NodesPerPush)))
        else $error("node allocation pointer out of step with stack depth");

    a_depth_max: assert property (@(posedge clk) disable iff (!rst_n)
        32'(depth_reg) <= 32'(MAX_ITEMS))
        else $error("stack depth beyond capacity");

    a_rsp_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result raised outside the finish step");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.status == ST_ERR) |-> (rsp_reg.answer == '0))
        else $error("error result with nonzero answer");

endmodule
